// ===== rtl/vmac_pkg.sv =====
// ============================================================================
// vmac_pkg: shared types and constants of the vector multiply-accumulate unit
// Opcode codes, the decoded per-request control bundle and the lane geometry.
// ============================================================================
package vmac_pkg;

    // Lane geometry.
    localparam int LANES      = 8;
    localparam int LANE_W     = 16;
    localparam int ACC_W      = 48;
    localparam int PROD_W     = 2 * (LANE_W + 1);
    localparam int MODE_W     = 4;
    localparam int VEC_W      = LANES * LANE_W;
    localparam int IN_DATA_W  = 264;
    localparam int OUT_DATA_W = VEC_W;

    // Rounding term added by the overwriting fractional multiplies.
    localparam logic [ACC_W-1:0] ROUND_HALF = 48'h0000_0000_8000;

    // Opcodes as they arrive on the input stream.
    typedef enum logic [MODE_W-1:0] {
        MODE_MULF = 4'd0,
        MODE_MULU = 4'd1,
        MODE_MUDL = 4'd2,
        MODE_MUDM = 4'd3,
        MODE_MUDN = 4'd4,
        MODE_MUDH = 4'd5,
        MODE_MACF = 4'd6,
        MODE_MACU = 4'd7,
        MODE_MADL = 4'd8,
        MODE_MADM = 4'd9,
        MODE_MADN = 4'd10,
        MODE_MADH = 4'd11
    } mode_t;

    // Product kind shared by the overwriting and the accumulating forms.
    typedef enum logic [2:0] {
        OP_FRAC  = 3'd0,
        OP_UFRAC = 3'd1,
        OP_LOW   = 3'd2,
        OP_MIDM  = 3'd3,
        OP_MIDN  = 3'd4,
        OP_HIGH  = 3'd5
    } op_t;

    // Decoded control that travels with a request down the lanes.
    typedef struct packed {
        logic legal;
        logic accum;
        op_t  op;
    } ctrl_t;

    // Opcode decoder. Unused codes give a request that leaves the
    // accumulators alone and returns zero.
    function automatic ctrl_t decode_mode(logic [MODE_W-1:0] mode);
        ctrl_t c;
        c.legal = 1'b1;
        c.accum = 1'b0;
        c.op    = OP_FRAC;
        unique case (mode)
            MODE_MULF: c.op = OP_FRAC;
            MODE_MULU: c.op = OP_UFRAC;
            MODE_MUDL: c.op = OP_LOW;
            MODE_MUDM: c.op = OP_MIDM;
            MODE_MUDN: c.op = OP_MIDN;
            MODE_MUDH: c.op = OP_HIGH;
            MODE_MACF: begin c.op = OP_FRAC;  c.accum = 1'b1; end
            MODE_MACU: begin c.op = OP_UFRAC; c.accum = 1'b1; end
            MODE_MADL: begin c.op = OP_LOW;   c.accum = 1'b1; end
            MODE_MADM: begin c.op = OP_MIDM;  c.accum = 1'b1; end
            MODE_MADN: begin c.op = OP_MIDN;  c.accum = 1'b1; end
            MODE_MADH: begin c.op = OP_HIGH;  c.accum = 1'b1; end
            default:   c.legal = 1'b0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/vmac_lane_mul.sv =====
// ============================================================================
// vmac_lane_mul: multiply stage of one lane
// Extends both 16-bit operands by the signedness the opcode asks for and
// registers their 17 x 17 bit signed product.
// ============================================================================
module vmac_lane_mul (
    input  logic                              clk,
    input  logic                              en,
    input  vmac_pkg::op_t                     op,
    input  logic [vmac_pkg::LANE_W-1:0]       vs,
    input  logic [vmac_pkg::LANE_W-1:0]       vt,
    output logic signed [vmac_pkg::PROD_W-1:0] prod_reg
);

    logic                                  vs_signed;
    logic                                  vt_signed;
    logic signed [vmac_pkg::LANE_W:0]      vs_ext;
    logic signed [vmac_pkg::LANE_W:0]      vt_ext;
    logic signed [vmac_pkg::PROD_W-1:0]    prod_next;

    // Operand signedness per product kind.
    always_comb
    begin
        vs_signed = 1'b1;
        vt_signed = 1'b1;
        case (op) inside
            vmac_pkg::OP_LOW:  begin vs_signed = 1'b0; vt_signed = 1'b0; end
            vmac_pkg::OP_MIDM: vt_signed = 1'b0;
            vmac_pkg::OP_MIDN: vs_signed = 1'b0;
            default:           ;
        endcase
    end

    // One signed multiplier covers all four sign combinations.
    assign vs_ext    = {vs_signed & vs[vmac_pkg::LANE_W-1], vs};
    assign vt_ext    = {vt_signed & vt[vmac_pkg::LANE_W-1], vt};
    assign prod_next = vs_ext * vt_ext;

    // Product register, loaded when the request enters the lane.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ===== rtl/vmac_lane_acc.sv =====
// ============================================================================
// vmac_lane_acc: accumulate and clamp stage of one lane
// Holds the lane's 48-bit accumulator, scales the product for the opcode,
// overwrites or adds, and registers the clamped 16-bit lane result.
// ============================================================================
module vmac_lane_acc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  vmac_pkg::ctrl_t               ctrl,
    input  logic signed [vmac_pkg::PROD_W-1:0] prod,
    output logic [vmac_pkg::LANE_W-1:0]   vd_reg
);

    logic [vmac_pkg::ACC_W-1:0]  acc_reg;
    logic [vmac_pkg::ACC_W-1:0]  acc_next;
    logic [vmac_pkg::ACC_W-1:0]  term;
    logic [vmac_pkg::ACC_W-1:0]  base;
    logic [vmac_pkg::LANE_W-1:0] vd_next;
    logic                        mid_fits;
    logic                        mid_neg;

    // Scale the product into accumulator position.
    always_comb
    begin
        term = '0;
        case (ctrl.op) inside
            vmac_pkg::OP_FRAC, vmac_pkg::OP_UFRAC:
                term = {{13{prod[33]}}, prod, 1'b0};
            vmac_pkg::OP_LOW:
                term = {32'd0, prod[31:16]};
            vmac_pkg::OP_MIDM, vmac_pkg::OP_MIDN:
                term = {{14{prod[33]}}, prod};
            vmac_pkg::OP_HIGH:
                term = {prod[31:0], 16'd0};
            default:
                term = '0;
        endcase
    end

    // Overwriting forms start from zero, or from the rounding half for the
    // fractional multiplies; accumulating forms start from the accumulator.
    always_comb
    begin
        if (ctrl.accum)
        begin
            base = acc_reg;
        end
        else if (ctrl.op == vmac_pkg::OP_FRAC || ctrl.op == vmac_pkg::OP_UFRAC)
        begin
            base = vmac_pkg::ROUND_HALF;
        end
        else
        begin
            base = '0;
        end
    end

    assign acc_next = base + term;

    // Bits 47:16 fit in 16 signed bits when bits 47:31 all agree.
    assign mid_fits = (&acc_next[47:31]) | ~(|acc_next[47:31]);
    assign mid_neg  = acc_next[47];

    // Output clamp selected by the opcode.
    always_comb
    begin
        vd_next = '0;
        if (ctrl.legal)
        begin
            case (ctrl.op) inside
                vmac_pkg::OP_UFRAC:
                    vd_next = mid_neg ? 16'h0000 :
                              (mid_fits ? acc_next[31:16] : 16'hFFFF);
                vmac_pkg::OP_LOW, vmac_pkg::OP_MIDN:
                    vd_next = mid_fits ? acc_next[15:0] :
                              (mid_neg ? 16'h0000 : 16'hFFFF);
                default:
                    vd_next = mid_fits ? acc_next[31:16] :
                              (mid_neg ? 16'h8000 : 16'h7FFF);
            endcase
        end
    end

    // Accumulator, cleared at reset and left alone by unused opcodes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (en && ctrl.legal)
        begin
            acc_reg <= acc_next;
        end
    end

    // Lane result register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vd_reg <= vd_next;
        end
    end

endmodule

// ===== rtl/vector_multiply_accumulate_unit.sv =====
// ============================================================================
// vector_multiply_accumulate_unit: eight-lane fixed-point multiply-accumulate
// Top level: stream handshake, opcode decode, lane array and result merge.
// ============================================================================
// Usage:
//   Each request on the s_axis channel carries one vector instruction: an
//   opcode and eight 16-bit lanes of each of vs and vt. Each of the eight
//   lanes multiplies its pair, then overwrites or adds into its own 48-bit
//   accumulator and returns one clamped 16-bit value. The m_axis channel
//   carries one result request per input request, in order.
//   An accepted request passes the multiply register, then the accumulate and
//   clamp stage, whose 48-bit add and clamp compare set the clock period,
//   before m_axis_tvalid rises. Throughput is one request per cycle while
//   m_axis is not stalled; back-to-back accumulating requests on a lane need
//   no gap because the accumulator is read and written in the same stage.
//   Reset clears every accumulator and empties both pipeline stages.
//   When the receiver stalls, the result holds on m_axis and the multiply
//   stage can still take one more request; after that s_axis_tready drops
//   until the result is taken.
// ============================================================================
module vector_multiply_accumulate_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[3:0], vs_lo[67:4], vs_hi[131:68], vt_lo[195:132], vt_hi[259:196]
    input  logic [vmac_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vd_lo[63:0], vd_hi[127:64]
    output logic [vmac_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic                                s1_valid_reg;
    logic                                s1_valid_next;
    vmac_pkg::ctrl_t                     s1_ctrl_reg;
    vmac_pkg::ctrl_t                     in_ctrl;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic                                out_ready;
    logic                                s1_load;
    logic                                s1_move;
    logic [vmac_pkg::VEC_W-1:0]          vs_vec;
    logic [vmac_pkg::VEC_W-1:0]          vt_vec;
    logic signed [vmac_pkg::PROD_W-1:0]  prod [vmac_pkg::LANES];
    logic [vmac_pkg::LANE_W-1:0]         vd_lane [vmac_pkg::LANES];

    // Pipeline flow control.
    assign out_ready      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready  = !s1_valid_reg || out_ready;
    assign s1_load        = s_axis_tvalid && s_axis_tready;
    assign s1_move        = s1_valid_reg && out_ready;
    assign s1_valid_next  = s1_load || (s1_valid_reg && !out_ready);
    assign out_valid_next = s1_move || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Opcode decode of the incoming request.
    assign in_ctrl = vmac_pkg::decode_mode(s_axis_tdata[3:0]);

    // Decoded opcode travels beside the products.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_ctrl_reg <= in_ctrl;
        end
    end

    assign vs_vec = s_axis_tdata[131:4];
    assign vt_vec = s_axis_tdata[259:132];

    // Lane array: one multiplier and one accumulator per lane.
    for (genvar i = 0; i < vmac_pkg::LANES; i++)
    begin : g_lane
        vmac_lane_mul u_mul (
            .clk      (clk),
            .en       (s1_load),
            .op       (in_ctrl.op),
            .vs       (vs_vec[i*vmac_pkg::LANE_W +: vmac_pkg::LANE_W]),
            .vt       (vt_vec[i*vmac_pkg::LANE_W +: vmac_pkg::LANE_W]),
            .prod_reg (prod[i])
        );

        vmac_lane_acc u_acc (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (s1_move),
            .ctrl   (s1_ctrl_reg),
            .prod   (prod[i]),
            .vd_reg (vd_lane[i])
        );

        // Merge the lane results into the output word.
        assign m_axis_tdata[i*vmac_pkg::LANE_W +: vmac_pkg::LANE_W] = vd_lane[i];
    end

    assign m_axis_tvalid = out_valid_reg;

endmodule

// ===== rtl/vmac_checker.sv =====
// ============================================================================
// vmac_checker: port-level checks for the multiply-accumulate unit
// Watches the stream ports for stall behaviour and pipeline latency.
// ============================================================================
module vmac_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // A stalled result stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its data.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // The input side only closes when a result is waiting and stalled.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input refused without a stalled result");

    // An accepted request reaches the output once the output stage is free.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 (!m_axis_tvalid || m_axis_tready)
        |=> m_axis_tvalid)
        else $error("accepted request did not reach the output");

endmodule

bind vector_multiply_accumulate_unit vmac_checker u_vmac_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for the vector multiply-accumulate unit
// A queue of vector requests is driven on s_axis with random gaps, and each
// accepted request is run through an eight-lane accumulator predictor.
// Results on m_axis are checked in order against the predicted lanes, with
// random and long receiver stalls.
// ============================================================================
module tb_top;

    // One queued vector request; drain_first holds it back until all
    // earlier results have been returned.
    typedef struct {
        logic [3:0]   mode;
        logic [127:0] vs;
        logic [127:0] vt;
        bit           drain_first;
    } vec_request_t;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [263:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;

    vec_request_t pending_requests[$];
    logic [127:0] expected_vd[$];
    logic [47:0]  lane_acc[vmac_pkg::LANES];

    bit in_taken = 1'b0;
    bit long_hold_done = 1'b0;
    int hold_cycles = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int total_requests = 0;

    // Neither side idles while this window of requests goes through.
    wire calm = (n_accepted >= 300) && (n_accepted < 450);

    vector_multiply_accumulate_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Predict the eight destination lanes of one request and update the
    // lane accumulators as the unit would.
    function automatic logic [127:0] compute_vector(input logic [3:0] mode,
                                                    input logic [127:0] vs,
                                                    input logic [127:0] vt);
        logic [127:0]       vd;
        logic [15:0]        a;
        logic [15:0]        b;
        longint             sa;
        longint             sb;
        longint             ua;
        longint             ub;
        longint             prod;
        logic [47:0]        acc;
        logic signed [31:0] mid;
        logic [15:0]        d;
        logic               accum;
        vmac_pkg::op_t      kind;
        vd = '0;
        if (mode > vmac_pkg::MODE_MADH)
            return vd;
        accum = (mode >= vmac_pkg::MODE_MACF);
        case (mode)
            vmac_pkg::MODE_MULF, vmac_pkg::MODE_MACF: kind = vmac_pkg::OP_FRAC;
            vmac_pkg::MODE_MULU, vmac_pkg::MODE_MACU: kind = vmac_pkg::OP_UFRAC;
            vmac_pkg::MODE_MUDL, vmac_pkg::MODE_MADL: kind = vmac_pkg::OP_LOW;
            vmac_pkg::MODE_MUDM, vmac_pkg::MODE_MADM: kind = vmac_pkg::OP_MIDM;
            vmac_pkg::MODE_MUDN, vmac_pkg::MODE_MADN: kind = vmac_pkg::OP_MIDN;
            default:                                  kind = vmac_pkg::OP_HIGH;
        endcase
        for (int i = 0; i < vmac_pkg::LANES; i++)
        begin
            a  = vs[16*i +: 16];
            b  = vt[16*i +: 16];
            sa = longint'($signed(a));
            sb = longint'($signed(b));
            ua = longint'(a);
            ub = longint'(b);
            case (kind)
                vmac_pkg::OP_FRAC, vmac_pkg::OP_UFRAC: prod = 2 * sa * sb;
                vmac_pkg::OP_LOW:                      prod = (ua * ub) >>> 16;
                vmac_pkg::OP_MIDM:                     prod = sa * ub;
                vmac_pkg::OP_MIDN:                     prod = ua * sb;
                default:                               prod = (sa * sb) * 65536;
            endcase
            if (accum)
                acc = lane_acc[i] + prod[47:0];
            else
            begin
                // Overwriting fractional forms round at bit 15.
                if (kind == vmac_pkg::OP_FRAC || kind == vmac_pkg::OP_UFRAC)
                    prod = prod + longint'(vmac_pkg::ROUND_HALF);
                acc = prod[47:0];
            end
            lane_acc[i] = acc;
            mid = acc[47:16];
            if (kind == vmac_pkg::OP_UFRAC)
                d = (mid < 0) ? 16'h0000 : (mid > 32767) ? 16'hFFFF : mid[15:0];
            else if (kind == vmac_pkg::OP_LOW || kind == vmac_pkg::OP_MIDN)
                d = (mid > 32767) ? 16'hFFFF : (mid < -32768) ? 16'h0000 : acc[15:0];
            else
                d = (mid > 32767) ? 16'h7FFF : (mid < -32768) ? 16'h8000 : mid[15:0];
            vd[16*i +: 16] = d;
        end
        return vd;
    endfunction

    // Lane value biased towards the extremes so that clamps are reached.
    function automatic logic [15:0] rand_lane();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [127:0] rand_vector();
        logic [127:0] v;
        for (int i = 0; i < vmac_pkg::LANES; i++)
            v[16*i +: 16] = rand_lane();
        return v;
    endfunction

    function automatic logic [127:0] fill_lanes(input logic [15:0] x);
        return {vmac_pkg::LANES{x}};
    endfunction

    task automatic add_request(input logic [3:0] mode, input logic [127:0] vs,
                               input logic [127:0] vt, input bit drain);
        vec_request_t r;
        r.mode        = mode;
        r.vs          = vs;
        r.vt          = vt;
        r.drain_first = drain;
        pending_requests.push_back(r);
    endtask

    // Request driver: presents queued requests on the falling edge.
    always @(negedge clk)
    begin : drive_requests
        vec_request_t r;
        bit           idle;
        idle = !calm && ($urandom_range(99) < 12);
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (pending_requests.size() == 0 || idle)
                s_axis_tvalid <= 1'b0;
            else if (pending_requests[0].drain_first && expected_vd.size() != 0)
                s_axis_tvalid <= 1'b0;
            else
            begin
                r = pending_requests.pop_front();
                s_axis_tdata  <= {4'b0000, r.vt[127:64], r.vt[63:0],
                                  r.vs[127:64], r.vs[63:0], r.mode};
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off that lets the
    // unit fill up and stall its input.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_cycles != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end
        else if (!long_hold_done && n_results >= 120)
        begin
            m_axis_tready  <= 1'b0;
            hold_cycles    <= 80;
            long_hold_done <= 1'b1;
        end
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 12);
    end

    // Monitor: check returned results first, then predict accepted requests.
    always @(posedge clk)
    begin : monitor
        logic [127:0] want;
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results <= n_results + 1;
            if (expected_vd.size() == 0)
            begin
                $error("unexpected result vd_lo=%h vd_hi=%h",
                       m_axis_tdata[63:0], m_axis_tdata[127:64]);
                n_errors++;
            end
            else
            begin
                want = expected_vd.pop_front();
                if (m_axis_tdata[63:0] !== want[63:0])
                begin
                    $error("vd_lo mismatch: expected %h, actual %h",
                           want[63:0], m_axis_tdata[63:0]);
                    n_errors++;
                end
                if (m_axis_tdata[127:64] !== want[127:64])
                begin
                    $error("vd_hi mismatch: expected %h, actual %h",
                           want[127:64], m_axis_tdata[127:64]);
                    n_errors++;
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_vd.push_back(compute_vector(s_axis_tdata[3:0],
                                                 s_axis_tdata[131:4],
                                                 s_axis_tdata[259:132]));
            n_accepted <= n_accepted + 1;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin : stimulus
        logic [127:0] vs_edge;
        logic [127:0] vt_edge;
        int           count;
        int           run_len;
        bit           drain;
        for (int i = 0; i < vmac_pkg::LANES; i++)
            lane_acc[i] = '0;
        vs_edge = {16'hFFFF, 16'h7FFF, 16'h0001, 16'h8000,
                   16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
        vt_edge = {16'h0001, 16'h8000, 16'hFFFF, 16'h0000,
                   16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000};

        // Every opcode on the lane extremes.
        for (int m = vmac_pkg::MODE_MULF; m <= vmac_pkg::MODE_MADH; m++)
            add_request(4'(m), vs_edge, vt_edge, 1'b0);
        // Unused opcodes leave the accumulators alone and return zero.
        for (int m = vmac_pkg::MODE_MADH + 1; m < 16; m++)
            add_request(4'(m), rand_vector(), rand_vector(), 1'b0);
        // Zero times a negative source under the rounding multiply.
        add_request(vmac_pkg::MODE_MULF, fill_lanes(16'h0000), fill_lanes(16'h8000),
                    1'b0);
        // Four products of 2^46 wrap every accumulator back to zero.
        add_request(vmac_pkg::MODE_MUDH, fill_lanes(16'h8000), fill_lanes(16'h8000),
                    1'b0);
        for (int k = 0; k < 3; k++)
            add_request(vmac_pkg::MODE_MADH, fill_lanes(16'h8000),
                        fill_lanes(16'h8000), 1'b0);

        // Random runs: mostly an overwrite followed by a chain of accumulates,
        // with the odd unused opcode in between.
        count = 0;
        while (count < 850)
        begin
            run_len = $urandom_range(15);
            for (int k = 0; k <= run_len; k++)
            begin
                drain = (count == 0) || (count == 500);
                if ($urandom_range(99) < 4)
                    add_request(4'($urandom_range(15, vmac_pkg::MODE_MADH + 1)),
                                rand_vector(), rand_vector(), drain);
                else if (k == 0 && $urandom_range(3) != 0)
                    add_request(4'($urandom_range(vmac_pkg::MODE_MUDH,
                                                  vmac_pkg::MODE_MULF)),
                                rand_vector(), rand_vector(), drain);
                else
                    add_request(4'($urandom_range(vmac_pkg::MODE_MADH,
                                                  vmac_pkg::MODE_MACF)),
                                rand_vector(), rand_vector(), drain);
                count++;
            end
        end
        total_requests = pending_requests.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (n_accepted != total_requests)
            @(posedge clk);
        while (expected_vd.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/vmac_pkg.sv
rtl/vmac_lane_mul.sv
rtl/vmac_lane_acc.sv
rtl/vector_multiply_accumulate_unit.sv
rtl/vmac_checker.sv
tb/tb_top.sv
